// File: design/inode_bitmap_allocator_unit_macros.svh
// assertion helpers for the inode bitmap allocator
`ifndef INODE_BITMAP_ALLOCATOR_UNIT_MACROS_SVH
`define INODE_BITMAP_ALLOCATOR_UNIT_MACROS_SVH

// property checked on every clock edge outside reset
`define IBMA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// same-cycle implication
`define IBMA_ASSERT_IMPL(lbl, ante, cons, msg) \
  `IBMA_ASSERT(lbl, (ante) |-> (cons), msg)

`endif

// File: design/ibma_pkg.sv
package ibma_pkg;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_FREE_RD,
    ST_FREE_WR,
    ST_RESP
  } state_e;

  localparam logic [1:0] OP_ALLOC = 2'd0;
  localparam logic [1:0] OP_FREE  = 2'd1;
  localparam logic [1:0] OP_COUNT = 2'd2;

  localparam logic [1:0] STAT_OK       = 2'd0;
  localparam logic [1:0] STAT_NO_SPACE = 2'd1;
  localparam logic [1:0] STAT_RANGE    = 2'd2;
  localparam logic [1:0] STAT_NO_BLOCK = 2'd3;

  localparam logic       REG_MAP_BLOCKS_USED = 1'b0;
  localparam logic       REG_START_LIMIT     = 1'b1;

  localparam int unsigned WORD_BITS = 16;
  localparam int unsigned WORD_LOG2 = 4;
  localparam logic [15:0] FULL_WORD = 16'hffff;

  // lowest clear bit of a word, caller makes sure one exists
  function automatic logic [3:0] first_zero16(input logic [15:0] w);
    logic [3:0] pos;
    pos = 4'd0;
    for (int b = WORD_BITS - 1; b >= 0; b--) begin
      if (!w[b]) begin
        pos = 4'(b);
      end
    end
    return pos;
  endfunction

  function automatic logic [4:0] zero_count16(input logic [15:0] w);
    logic [4:0] n;
    n = 5'd0;
    for (int b = 0; b < WORD_BITS; b++) begin
      n = n + 5'(!w[b]);
    end
    return n;
  endfunction

endpackage

// File: design/inode_bitmap_allocator_unit.sv
// channel  direction  handshake               payload
// in       input      in_valid_i / in_ready_o  op_i, inode_number_i
// out      output     out_valid_o / out_ready_i status_o, allocated_number_o, free_count_o
// cfg      input      psel/penable/pwrite      paddr, pwdata, prdata (pready tied high)
//
// count, and an allocate that finds no space, read every word of the scan before the
//   result, one bitmap word per cycle through the single read port of the bitmap ram
//   (nwords = words in the scan); with no block in use no word is read
// an allocate that finds a clear bit ends the scan at that word
// free: read with range check, modify-write, result; the write is skipped when rejected
// after reset the ram is cleared one word a cycle, TOTAL_WORDS words (1024 by
//   default), with in_ready_o low; config writes are taken meanwhile
// one item at a time; the result register lets the next item start while out stalls
`include "inode_bitmap_allocator_unit_macros.svh"

module inode_bitmap_allocator_unit import ibma_pkg::*; #(
  parameter int unsigned MAP_BLOCKS      = 4,
  parameter int unsigned BLOCK_BITS_LOG2 = 12
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // item in
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  op_i,
  input  logic [31:0] inode_number_i,
  // result out
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  status_o,
  output logic [13:0] allocated_number_o,
  output logic [14:0] free_count_o,
  // config port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned MAP_BLOCK_BITS  = 1 << BLOCK_BITS_LOG2;
  localparam int unsigned WORDS_PER_BLOCK = MAP_BLOCK_BITS / WORD_BITS;
  localparam int unsigned TOTAL_WORDS     = MAP_BLOCKS * WORDS_PER_BLOCK;
  localparam int unsigned AW = (TOTAL_WORDS > 1) ? $clog2(TOTAL_WORDS) : 1;
  localparam int unsigned CW = $clog2(TOTAL_WORDS + 1);
  localparam int unsigned WPB_LOG2 = BLOCK_BITS_LOG2 - WORD_LOG2;

  // bitmap ram, busy bit = 1
  logic [15:0] mem_q [TOTAL_WORDS];
  logic [15:0] rdata_q;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [AW-1:0] mem_raddr;
  logic [15:0]   mem_wdata;

  state_e state_q, state_d;

  logic [AW-1:0] clr_q, clr_d;
  logic [CW-1:0] scan_q, scan_d;
  logic [CW-1:0] nwords_q, nwords_d;
  logic          rv_q, rv_d;          // rdata_q holds the word at raddr_q
  logic [AW-1:0] raddr_q, raddr_d;
  logic [1:0]    op_q, op_d;
  logic [31:0]   num_q, num_d;
  logic [31:0]   limit_q, limit_d;
  logic [2:0]    mbu_q;
  logic [13:0]   sil_q;
  logic [14:0]   cnt_q, cnt_d;

  // pending result
  logic [1:0]  res_status_q, res_status_d;
  logic [13:0] res_alloc_q, res_alloc_d;
  logic [14:0] res_count_q, res_count_d;

  // output register
  logic        out_valid_q, out_valid_d;
  logic [1:0]  out_status_q, out_status_d;
  logic [13:0] out_alloc_q, out_alloc_d;
  logic [14:0] out_count_q, out_count_d;

  logic cfg_we;
  assign cfg_we = psel && penable && pwrite;
  assign pready = 1'b1;

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_START_LIMIT) begin
      prdata = 32'(sil_q);
    end else begin
      prdata = 32'(mbu_q);
    end
  end

  // blocks in use, capped at the store
  logic [31:0] used32;
  assign used32 = (32'(mbu_q) > 32'(MAP_BLOCKS)) ? 32'(MAP_BLOCKS) : 32'(mbu_q);

  // words covered by limit+1 bits, rounded up to whole blocks
  logic [33:0] cnt_blocks, cnt_blocks_cap;
  logic [CW-1:0] alloc_words, count_words;
  assign cnt_blocks     = ({2'b00, limit_q} + 34'(MAP_BLOCK_BITS)) >> BLOCK_BITS_LOG2;
  assign cnt_blocks_cap = (cnt_blocks > 34'(used32)) ? 34'(used32) : cnt_blocks;
  assign alloc_words    = CW'(used32 << WPB_LOG2);
  assign count_words    = CW'(cnt_blocks_cap << WPB_LOG2);

  // word under test in the scan
  logic [3:0]     zpos;
  logic [AW+3:0]  jnum;
  logic [31:0]    jnum32;
  logic [31:0]    limit_inc;
  logic           scan_done;
  logic           word_has_zero;
  logic [31:0]    free_blk;
  assign zpos          = first_zero16(rdata_q);
  assign jnum          = {raddr_q, zpos};
  assign jnum32        = 32'(jnum);
  assign limit_inc     = limit_q + 32'd1;
  assign scan_done     = !rv_q && (scan_q == nwords_q);
  assign word_has_zero = rdata_q != FULL_WORD;
  assign free_blk      = num_q >> BLOCK_BITS_LOG2;

  logic free_err;
  assign free_err = (num_q == 32'd0) || (num_q > limit_q) || (free_blk >= used32);

  logic out_free;
  assign out_free = !out_valid_q || out_ready_i;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        if (clr_q == AW'(TOTAL_WORDS - 1)) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          case (op_i)
            OP_ALLOC, OP_COUNT: state_d = ST_SCAN;
            OP_FREE:            state_d = ST_FREE_RD;
            default:            state_d = ST_RESP;
          endcase
        end
      end
      ST_SCAN: begin
        if (op_q == OP_ALLOC && rv_q && word_has_zero) begin
          state_d = ST_RESP;
        end else if (scan_done) begin
          state_d = ST_RESP;
        end
      end
      ST_FREE_RD: state_d = free_err ? ST_RESP : ST_FREE_WR;
      ST_FREE_WR: state_d = ST_RESP;
      ST_RESP: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_CLEAR;
    endcase
  end

  // datapath and ram control
  always_comb begin
    clr_d        = clr_q;
    scan_d       = scan_q;
    nwords_d     = nwords_q;
    rv_d         = 1'b0;
    raddr_d      = raddr_q;
    op_d         = op_q;
    num_d        = num_q;
    limit_d      = limit_q;
    cnt_d        = cnt_q;
    res_status_d = res_status_q;
    res_alloc_d  = res_alloc_q;
    res_count_d  = res_count_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    out_status_d = out_status_q;
    out_alloc_d  = out_alloc_q;
    out_count_d  = out_count_q;
    mem_we       = 1'b0;
    mem_waddr    = clr_q;
    mem_wdata    = '0;
    mem_raddr    = scan_q[AW-1:0];

    case (state_q)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        mem_wdata = '0;
        clr_d     = clr_q + AW'(1);
      end
      ST_IDLE: begin
        scan_d = '0;
        cnt_d  = '0;
        if (in_valid_i) begin
          op_d         = op_i;
          num_d        = inode_number_i;
          nwords_d     = (op_i == OP_COUNT) ? count_words : alloc_words;
          res_status_d = STAT_OK;
          res_alloc_d  = '0;
          res_count_d  = '0;
        end
      end
      ST_SCAN: begin
        // issue the next read while checking the word read last cycle
        if (scan_q != nwords_q) begin
          rv_d    = 1'b1;
          raddr_d = scan_q[AW-1:0];
          scan_d  = scan_q + CW'(1);
        end
        if (rv_q) begin
          if (op_q == OP_COUNT) begin
            cnt_d = cnt_q + 15'(zero_count16(rdata_q));
          end else if (word_has_zero) begin
            mem_we    = 1'b1;
            mem_waddr = raddr_q;
            mem_wdata = rdata_q | (16'd1 << zpos);
            limit_d   = limit_inc;
            if (jnum == '0 || jnum32 > limit_inc) begin
              res_status_d = STAT_RANGE;
            end else begin
              res_alloc_d = jnum32[13:0];
            end
          end
        end else if (scan_done) begin
          if (op_q == OP_COUNT) begin
            res_count_d = cnt_q;
          end else begin
            res_status_d = STAT_NO_SPACE;
          end
        end
      end
      ST_FREE_RD: begin
        mem_raddr = num_q[AW+3:4];
        if ((num_q == 32'd0) || (num_q > limit_q)) begin
          res_status_d = STAT_RANGE;
        end else if (free_blk >= used32) begin
          res_status_d = STAT_NO_BLOCK;
        end
      end
      ST_FREE_WR: begin
        mem_we    = 1'b1;
        mem_waddr = num_q[AW+3:4];
        mem_wdata = rdata_q & ~(16'd1 << num_q[3:0]);
      end
      ST_RESP: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_status_d = res_status_q;
          out_alloc_d  = res_alloc_q;
          out_count_d  = res_count_q;
        end
      end
      default: ;
    endcase

    // a limit write reloads the running limit
    if (cfg_we && paddr[2] == REG_START_LIMIT) begin
      limit_d = 32'(pwdata[13:0]);
    end
  end

  // bitmap ram
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    rdata_q <= mem_q[mem_raddr];
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      rv_q        <= 1'b0;
      out_valid_q <= 1'b0;
      limit_q     <= '0;
      mbu_q       <= 3'd1;
      sil_q       <= '0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      rv_q        <= rv_d;
      out_valid_q <= out_valid_d;
      limit_q     <= limit_d;
      if (cfg_we && paddr[2] == REG_MAP_BLOCKS_USED) begin
        mbu_q <= pwdata[2:0];
      end
      if (cfg_we && paddr[2] == REG_START_LIMIT) begin
        sil_q <= pwdata[13:0];
      end
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    scan_q       <= scan_d;
    nwords_q     <= nwords_d;
    raddr_q      <= raddr_d;
    op_q         <= op_d;
    num_q        <= num_d;
    cnt_q        <= cnt_d;
    res_status_q <= res_status_d;
    res_alloc_q  <= res_alloc_d;
    res_count_q  <= res_count_d;
    out_status_q <= out_status_d;
    out_alloc_q  <= out_alloc_d;
    out_count_q  <= out_count_d;
  end

  assign in_ready_o         = state_q == ST_IDLE;
  assign out_valid_o        = out_valid_q;
  assign status_o           = out_status_q;
  assign allocated_number_o = out_alloc_q;
  assign free_count_o       = out_count_q;

  // checks
  `IBMA_ASSERT_IMPL(a_no_result_in_clear, state_q == ST_CLEAR, !out_valid_q,
    "result during ram clear")
  `IBMA_ASSERT_IMPL(a_result_from_resp, out_valid_q && !$past(out_valid_q),
    $past(state_q) == ST_RESP, "result loaded outside resp")
  `IBMA_ASSERT_IMPL(a_error_zero_payload, out_valid_o && status_o != STAT_OK,
    allocated_number_o == '0 && free_count_o == '0, "error result with payload")
  `IBMA_ASSERT_IMPL(a_write_in_range, mem_we, 32'(mem_waddr) < 32'(TOTAL_WORDS),
    "bitmap write out of range")

endmodule
